@@ rtl/rpu_pkg.sv @@
// Package for the x86-64 relocation patch unit: payload structs, status codes,
// relocation type numbers and the type decode function. No dependencies.
`default_nettype none

package rpu_pkg;

  // Status codes returned with every result item.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_OFFSET      = 4'd1;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd2;
  localparam logic [3:0] ST_FIELD       = 4'd3;
  localparam logic [3:0] ST_UNRESOLVED  = 4'd4;
  localparam logic [3:0] ST_OVERFLOW    = 4'd5;
  localparam logic [3:0] ST_UNDERFLOW   = 4'd6;
  localparam logic [3:0] ST_NOPREFIX    = 4'd7;
  localparam logic [3:0] ST_OPCODE      = 4'd8;

  // Relocation type numbers from the psABI.
  localparam logic [5:0] R_NONE          = 6'd0;
  localparam logic [5:0] R_64            = 6'd1;
  localparam logic [5:0] R_PC32          = 6'd2;
  localparam logic [5:0] R_PLT32         = 6'd4;
  localparam logic [5:0] R_GOTPCREL      = 6'd9;
  localparam logic [5:0] R_32            = 6'd10;
  localparam logic [5:0] R_32S           = 6'd11;
  localparam logic [5:0] R_16            = 6'd12;
  localparam logic [5:0] R_PC16          = 6'd13;
  localparam logic [5:0] R_8             = 6'd14;
  localparam logic [5:0] R_PC8           = 6'd15;
  localparam logic [5:0] R_PC64          = 6'd24;
  localparam logic [5:0] R_SIZE32        = 6'd32;
  localparam logic [5:0] R_SIZE64        = 6'd33;
  localparam logic [5:0] R_GOTPCRELX     = 6'd41;
  localparam logic [5:0] R_REX_GOTPCRELX = 6'd42;

  // Opcode bytes used by GOT-relative relaxation.
  localparam logic [7:0] OP_MOV_LOAD = 8'h8b;
  localparam logic [7:0] OP_LEA      = 8'h8d;
  localparam logic [7:0] OP_GRP5     = 8'hff;
  localparam logic [7:0] MODRM_CALL  = 8'h15;
  localparam logic [7:0] MODRM_JMP   = 8'h25;
  localparam logic [7:0] OP_ADDR32   = 8'h67;
  localparam logic [7:0] OP_CALL     = 8'he8;
  localparam logic [7:0] OP_JMP      = 8'he9;

  // Range check applied to the final value.
  typedef enum logic [1:0] {
    CHK_WRAP     = 2'd0,
    CHK_SIGNED   = 2'd1,
    CHK_UNSIGNED = 2'd2,
    CHK_U32      = 2'd3
  } chk_t;

  // One relocation record.
  typedef struct packed {
    logic [5:0]         mode;
    logic [63:0]        symbol_value;
    logic [63:0]        symbol_size;
    logic               symbol_ok;
    logic signed [63:0] addend;
    logic               explicit_addend;
    logic [63:0]        field_bytes;
    logic [63:0]        place_address;
    logic [31:0]        field_offset;
    logic [31:0]        section_size;
    logic [15:0]        prefix_bytes;
  } in_t;

  // One patch result.
  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] patch_value;
    logic [3:0]  patch_bytes;
    logic        prefix_write;
    logic [15:0] new_prefix;
  } out_t;

  // Static properties of one relocation type.
  typedef struct packed {
    logic [3:0] width;
    logic       pcrel;
    logic       use_size;
    logic       got;
    chk_t       chk;
  } mode_info_t;

  // Decode stage to add stage.
  typedef struct packed {
    logic        done;
    logic [3:0]  status;
    logic [63:0] base;
    logic [63:0] addend;
    logic [63:0] place;
    logic        pcrel;
    chk_t        chk;
    logic [3:0]  width;
    logic        prefix_write;
    logic [15:0] new_prefix;
  } dec_t;

  // Add stage to check stage.
  typedef struct packed {
    logic        done;
    logic [3:0]  status;
    logic [63:0] sum;
    logic [63:0] place;
    logic        pcrel;
    chk_t        chk;
    logic [3:0]  width;
    logic        prefix_write;
    logic [15:0] new_prefix;
  } sum_t;

  // Field width in bytes (zero for unsupported types) and operand selection.
  function automatic mode_info_t mode_info(input logic [5:0] m);
    mode_info_t mi;
    mi = '{width: 4'd0, pcrel: 1'b0, use_size: 1'b0, got: 1'b0, chk: CHK_WRAP};
    unique case (m) inside
      R_64:     mi.width = 4'd8;
      R_PC64: begin
        mi.width = 4'd8;
        mi.pcrel = 1'b1;
      end
      R_SIZE64: begin
        mi.width    = 4'd8;
        mi.use_size = 1'b1;
      end
      R_PC32, R_PLT32: begin
        mi.width = 4'd4;
        mi.pcrel = 1'b1;
        mi.chk   = CHK_SIGNED;
      end
      R_GOTPCREL, R_GOTPCRELX, R_REX_GOTPCRELX: begin
        mi.width = 4'd4;
        mi.pcrel = 1'b1;
        mi.got   = 1'b1;
        mi.chk   = CHK_SIGNED;
      end
      R_32: begin
        mi.width = 4'd4;
        mi.chk   = CHK_U32;
      end
      R_32S: begin
        mi.width = 4'd4;
        mi.chk   = CHK_SIGNED;
      end
      R_SIZE32: begin
        mi.width    = 4'd4;
        mi.use_size = 1'b1;
        mi.chk      = CHK_UNSIGNED;
      end
      R_16: begin
        mi.width = 4'd2;
        mi.chk   = CHK_UNSIGNED;
      end
      R_PC16: begin
        mi.width = 4'd2;
        mi.pcrel = 1'b1;
        mi.chk   = CHK_SIGNED;
      end
      R_8: begin
        mi.width = 4'd1;
        mi.chk   = CHK_UNSIGNED;
      end
      R_PC8: begin
        mi.width = 4'd1;
        mi.pcrel = 1'b1;
        mi.chk   = CHK_SIGNED;
      end
      default: mi.width = 4'd0;
    endcase
    return mi;
  endfunction

endpackage

`default_nettype wire

@@ rtl/x86_64_relocation_patch_unit.sv @@
// x86-64 ELF relocation patch unit, top level. Uses rpu_pkg, rpu_decode,
// rpu_add and rpu_check.
// Each stage holds one item; items pass decode, add and check, each one registered.
// Throughput: one item per cycle while out_ready is high; a stage refills as it drains.
// Reset (rst_n low, synchronous) empties every stage; payload registers keep old data.
`default_nettype none

module x86_64_relocation_patch_unit
  import rpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic sum_valid;
  logic sum_ready;
  sum_t sum_data;

  // Stage 1: decode and early checks.
  rpu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  // Stage 2: base plus addend.
  rpu_add u_add (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  // Stage 3: place subtraction, range check, output register.
  rpu_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // An error result never carries a write.
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.patch_bytes == 4'd0 && out_data.patch_value == 64'd0 &&
      !out_data.prefix_write)
    else $error("error result carries a write");

  // A relaxed prefix always goes with a 32-bit field write.
  a_prefix_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.prefix_write |->
      out_data.status == ST_OK && out_data.patch_bytes == 4'd4)
    else $error("prefix rewrite without a 32-bit field");

  // An empty pipeline always takes a new item.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !dec_valid && !sum_valid && !out_valid |-> in_ready)
    else $error("empty pipeline stalls input");
`endif

endmodule

`default_nettype wire

@@ rtl/rpu_decode.sv @@
// First pipeline stage: type decode, early error checks, implicit addend and
// opcode relaxation. Depends on rpu_pkg.
`default_nettype none

module rpu_decode
  import rpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      dec_valid,
  input  wire logic dec_ready,
  output dec_t      dec_data
);

  logic       valid_r;
  dec_t       data_r;
  dec_t       data_nxt;
  mode_info_t mi;
  logic [31:0] room;
  logic [63:0] impl_addend;
  logic [7:0]  pre_hi;
  logic [7:0]  pre_lo;
  logic        relax_ok;
  logic [15:0] relax_prefix;

  assign mi     = mode_info(in_data.mode);
  assign room   = in_data.section_size - in_data.field_offset;
  assign pre_hi = in_data.prefix_bytes[15:8];
  assign pre_lo = in_data.prefix_bytes[7:0];

  // Implicit addend: current field bytes sign-extended from the field width.
  always_comb begin
    case (mi.width)
      4'd1:    impl_addend = {{56{in_data.field_bytes[7]}}, in_data.field_bytes[7:0]};
      4'd2:    impl_addend = {{48{in_data.field_bytes[15]}}, in_data.field_bytes[15:0]};
      4'd4:    impl_addend = {{32{in_data.field_bytes[31]}}, in_data.field_bytes[31:0]};
      default: impl_addend = in_data.field_bytes;
    endcase
  end

  // Rewrite of the two opcode bytes in front of a GOT-relative field.
  always_comb begin
    relax_ok     = 1'b1;
    relax_prefix = 16'd0;
    if (pre_hi == OP_MOV_LOAD) begin
      relax_prefix = {OP_LEA, pre_lo};
    end else if (pre_hi == OP_GRP5 && pre_lo == MODRM_CALL) begin
      relax_prefix = {OP_ADDR32, OP_CALL};
    end else if (pre_hi == OP_GRP5 && pre_lo == MODRM_JMP) begin
      relax_prefix = {OP_ADDR32, OP_JMP};
    end else begin
      relax_ok = 1'b0;
    end
  end

  // Checks in priority order; done marks a result that is already settled.
  always_comb begin
    data_nxt.done         = 1'b1;
    data_nxt.status       = ST_OK;
    data_nxt.base         = mi.use_size ? in_data.symbol_size : in_data.symbol_value;
    data_nxt.addend       = in_data.explicit_addend ? in_data.addend : impl_addend;
    data_nxt.place        = in_data.place_address;
    data_nxt.pcrel        = mi.pcrel;
    data_nxt.chk          = mi.chk;
    data_nxt.width        = mi.width;
    data_nxt.prefix_write = 1'b0;
    data_nxt.new_prefix   = 16'd0;
    if (in_data.mode == R_NONE) begin
      data_nxt.status = ST_OK;
    end else if (in_data.field_offset > in_data.section_size) begin
      data_nxt.status = ST_OFFSET;
    end else if (mi.width == 4'd0) begin
      data_nxt.status = ST_UNSUPPORTED;
    end else if ({28'd0, mi.width} > room) begin
      data_nxt.status = ST_FIELD;
    end else if (!in_data.symbol_ok) begin
      data_nxt.status = ST_UNRESOLVED;
    end else if (mi.got && in_data.field_offset < 32'd2) begin
      data_nxt.status = ST_NOPREFIX;
    end else if (mi.got && !relax_ok) begin
      data_nxt.status = ST_OPCODE;
    end else begin
      data_nxt.done         = 1'b0;
      data_nxt.prefix_write = mi.got;
      data_nxt.new_prefix   = mi.got ? relax_prefix : 16'd0;
    end
  end

  // Stage register; it refills whenever it is empty or drains this cycle.
  assign in_ready = !valid_r || dec_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/rpu_add.sv @@
// Second pipeline stage: adds the base operand (S or Z) and the addend.
// Depends on rpu_pkg.
`default_nettype none

module rpu_add
  import rpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic dec_valid,
  output logic      dec_ready,
  input  wire dec_t dec_data,
  output logic      sum_valid,
  input  wire logic sum_ready,
  output sum_t      sum_data
);

  logic valid_r;
  sum_t data_r;
  sum_t data_nxt;

  // Base plus addend, modulo 2^64.
  always_comb begin
    data_nxt.done         = dec_data.done;
    data_nxt.status       = dec_data.status;
    data_nxt.sum          = dec_data.base + dec_data.addend;
    data_nxt.place        = dec_data.place;
    data_nxt.pcrel        = dec_data.pcrel;
    data_nxt.chk          = dec_data.chk;
    data_nxt.width        = dec_data.width;
    data_nxt.prefix_write = dec_data.prefix_write;
    data_nxt.new_prefix   = dec_data.new_prefix;
  end

  // Stage register.
  assign dec_ready = !valid_r || sum_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) begin
      data_r <= data_nxt;
    end
  end

  assign sum_valid = valid_r;
  assign sum_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/rpu_check.sv @@
// Third pipeline stage: subtracts the place for PC-relative types, checks the
// range for the field width and forms the result item. Depends on rpu_pkg.
`default_nettype none

module rpu_check
  import rpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic sum_valid,
  output logic      sum_ready,
  input  wire sum_t sum_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic        valid_r;
  out_t        data_r;
  out_t        data_nxt;
  logic [63:0] value;
  logic [63:0] masked;
  logic        fits_s;
  logic        fits_u;

  assign value = sum_data.pcrel ? (sum_data.sum - sum_data.place) : sum_data.sum;

  // Signed fit: all bits from the field's sign bit up agree. Unsigned fit:
  // nothing above the field.
  always_comb begin
    case (sum_data.width)
      4'd1: begin
        fits_s = (&value[63:7]) || !(|value[63:7]);
        fits_u = !(|value[63:8]);
        masked = {56'd0, value[7:0]};
      end
      4'd2: begin
        fits_s = (&value[63:15]) || !(|value[63:15]);
        fits_u = !(|value[63:16]);
        masked = {48'd0, value[15:0]};
      end
      4'd4: begin
        fits_s = (&value[63:31]) || !(|value[63:31]);
        fits_u = !(|value[63:32]);
        masked = {32'd0, value[31:0]};
      end
      default: begin
        fits_s = 1'b1;
        fits_u = 1'b1;
        masked = value;
      end
    endcase
  end

  // Final status; any error clears the write.
  always_comb begin
    data_nxt.status       = ST_OK;
    data_nxt.patch_value  = masked;
    data_nxt.patch_bytes  = sum_data.width;
    data_nxt.prefix_write = sum_data.prefix_write;
    data_nxt.new_prefix   = sum_data.new_prefix;
    if (sum_data.done) begin
      data_nxt.status = sum_data.status;
    end else begin
      case (sum_data.chk)
        CHK_SIGNED:   if (!fits_s) data_nxt.status = ST_OVERFLOW;
        CHK_UNSIGNED: if (!fits_u) data_nxt.status = ST_OVERFLOW;
        CHK_U32: begin
          if (value[63]) data_nxt.status = ST_UNDERFLOW;
          else if (!fits_u) data_nxt.status = ST_OVERFLOW;
        end
        default: data_nxt.status = ST_OK;
      endcase
    end
    if (sum_data.done || data_nxt.status != ST_OK) begin
      data_nxt.patch_value  = 64'd0;
      data_nxt.patch_bytes  = 4'd0;
      data_nxt.prefix_write = 1'b0;
      data_nxt.new_prefix   = 16'd0;
    end
  end

  // Output register.
  assign sum_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sum_ready) begin
      valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ tb/x86_64_relocation_patch_unit_tb.sv @@
// Self-checking testbench for the x86-64 relocation patch unit: a directed table
// followed by random relocation records, checked against table results or a predictor.
// Depends on rpu_pkg and x86_64_relocation_patch_unit.
`default_nettype none

module x86_64_relocation_patch_unit_tb;
  import rpu_pkg::*;

  // Type numbers that the unit does not support, used by name in the table.
  localparam logic [5:0] R_GOT32    = 6'd3;
  localparam logic [5:0] R_TYPE_TOP = 6'd63;

  localparam int RECORDS_PER_PHASE = 500;
  localparam int STALL_LIMIT       = 5000;
  localparam int DRAIN_CYCLES      = 8;

  typedef struct {
    in_t  rec;
    bit   typed;
    out_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t       expected_patches[$];
  table_row_t directed_rows[$];
  out_t       oldest_patch;
  int         send_idle_pct;
  int         stall_pct;
  int         idle_cycles;
  int         errors;
  int         records_sent;
  int         results_checked;
  int         patched_ok;
  int         relaxed;

  x86_64_relocation_patch_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Field width in bytes for each supported type; zero marks an unsupported type.
  function automatic logic [3:0] field_width(input logic [5:0] m);
    case (m) inside
      R_64, R_PC64, R_SIZE64: field_width = 4'd8;
      R_PC32, R_PLT32, R_GOTPCREL, R_32, R_32S, R_SIZE32, R_GOTPCRELX,
      R_REX_GOTPCRELX: field_width = 4'd4;
      R_16, R_PC16: field_width = 4'd2;
      R_8, R_PC8: field_width = 4'd1;
      default: field_width = 4'd0;
    endcase
  endfunction

  // True when v, read as a signed 64-bit number, fits a signed field of nbits.
  function automatic bit fits_signed_field(input logic [63:0] v, input int nbits);
    logic [63:0] half;
    half = 64'd1 << (nbits - 1);
    fits_signed_field = (v + half) < (half << 1);
  endfunction

  // Expected result for one relocation record.
  function automatic out_t predict_patch(input in_t r);
    out_t        res;
    logic [3:0]  st;
    logic [3:0]  w;
    logic [63:0] mask;
    logic [63:0] sign;
    logic [63:0] a;
    logic [63:0] v;
    logic [15:0] np;
    bit          relax;
    res   = '0;
    st    = ST_OK;
    w     = field_width(r.mode);
    v     = '0;
    np    = '0;
    relax = 1'b0;
    if (r.mode == R_NONE) begin
      return res;
    end
    if (r.field_offset > r.section_size) begin
      st = ST_OFFSET;
    end else if (w == 4'd0) begin
      st = ST_UNSUPPORTED;
    end else if (32'(w) > r.section_size - r.field_offset) begin
      st = ST_FIELD;
    end else if (!r.symbol_ok) begin
      st = ST_UNRESOLVED;
    end else begin
      mask = (w == 4'd8) ? '1 : (64'd1 << (8 * w)) - 64'd1;
      // An implicit addend is the current field sign-extended from its width.
      sign = 64'd1 << (8 * w - 1);
      a = r.explicit_addend ? r.addend : ((r.field_bytes & mask) ^ sign) - sign;
      case (r.mode) inside
        R_64:     v = r.symbol_value + a;
        R_PC64:   v = r.symbol_value + a - r.place_address;
        R_SIZE64: v = r.symbol_size + a;
        R_PC32, R_PLT32, R_PC16, R_PC8: begin
          v = r.symbol_value + a - r.place_address;
          if (!fits_signed_field(v, 8 * w)) st = ST_OVERFLOW;
        end
        R_32S: begin
          v = r.symbol_value + a;
          if (!fits_signed_field(v, 32)) st = ST_OVERFLOW;
        end
        R_32: begin
          v = r.symbol_value + a;
          if (v[63]) st = ST_UNDERFLOW;
          else if (v > 64'hFFFF_FFFF) st = ST_OVERFLOW;
        end
        R_16, R_8, R_SIZE32: begin
          v = (r.mode == R_SIZE32) ? r.symbol_size + a : r.symbol_value + a;
          if (v[63] || v > mask) st = ST_OVERFLOW;
        end
        default: begin
          // GOT-relative loads and branches are relaxed to their direct forms.
          if (r.field_offset < 32'd2) begin
            st = ST_NOPREFIX;
          end else if (r.prefix_bytes[15:8] == OP_MOV_LOAD) begin
            np = {OP_LEA, r.prefix_bytes[7:0]};
          end else if (r.prefix_bytes == {OP_GRP5, MODRM_CALL}) begin
            np = {OP_ADDR32, OP_CALL};
          end else if (r.prefix_bytes == {OP_GRP5, MODRM_JMP}) begin
            np = {OP_ADDR32, OP_JMP};
          end else begin
            st = ST_OPCODE;
          end
          if (st == ST_OK) begin
            v = r.symbol_value + a - r.place_address;
            if (!fits_signed_field(v, 32)) st = ST_OVERFLOW;
            relax = 1'b1;
          end
        end
      endcase
      if (st == ST_OK) begin
        res.patch_value  = v & mask;
        res.patch_bytes  = w;
        res.prefix_write = relax;
        res.new_prefix   = relax ? np : 16'h0000;
      end
    end
    res.status = st;
    return res;
  endfunction

  function automatic out_t bare_status(input logic [3:0] st);
    bare_status = {st, 64'd0, 4'd0, 1'b0, 16'd0};
  endfunction

  function automatic out_t plain_write(input logic [63:0] v, input logic [3:0] nb);
    plain_write = {ST_OK, v, nb, 1'b0, 16'd0};
  endfunction

  // Base record for the table: resolved symbol, explicit addend, room to spare.
  function automatic in_t base_record(input logic [5:0] m, input logic [63:0] s,
                                      input logic [63:0] a, input logic [63:0] p);
    in_t r;
    r                 = '0;
    r.mode            = m;
    r.symbol_value    = s;
    r.addend          = a;
    r.explicit_addend = 1'b1;
    r.symbol_ok       = 1'b1;
    r.place_address   = p;
    r.field_offset    = 32'd8;
    r.section_size    = 32'd64;
    r.prefix_bytes    = {OP_MOV_LOAD, 8'h05};
    return r;
  endfunction

  task automatic add_row(input in_t r, input bit typed, input out_t want);
    table_row_t row;
    row.rec   = r;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [63:0] rnd64();
    rnd64 = {$urandom(), $urandom()};
  endfunction

  // Random value sign-extended from the given number of bits.
  function automatic logic [63:0] rnd_signed(input int bits);
    logic signed [63:0] t;
    t = rnd64();
    t = t <<< (64 - bits);
    rnd_signed = t >>> (64 - bits);
  endfunction

  function automatic logic [63:0] rnd_unsigned(input int bits);
    rnd_unsigned = rnd64() >> (64 - bits);
  endfunction

  function automatic logic [5:0] known_type(input int idx);
    case (idx)
      0:  known_type = R_64;
      1:  known_type = R_PC32;
      2:  known_type = R_PLT32;
      3:  known_type = R_GOTPCREL;
      4:  known_type = R_32;
      5:  known_type = R_32S;
      6:  known_type = R_16;
      7:  known_type = R_PC16;
      8:  known_type = R_8;
      9:  known_type = R_PC8;
      10: known_type = R_PC64;
      11: known_type = R_SIZE32;
      12: known_type = R_SIZE64;
      13: known_type = R_GOTPCRELX;
      14: known_type = R_REX_GOTPCRELX;
      default: known_type = R_NONE;
    endcase
  endfunction

  // Mostly well-formed records whose values sit near the edges of each field's range.
  function automatic in_t random_record();
    in_t r;
    int  w;
    int  mag;
    int  pick;
    pick = $urandom_range(0, 99);
    r.mode = (pick < 90) ? known_type($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
    w = int'(field_width(r.mode));
    mag = (w == 0) ? 32 : 8 * w;
    case ($urandom_range(0, 3))
      0: mag = mag - 1;
      2: mag = mag + 1;
      3: mag = 64;
      default: mag = mag;
    endcase
    if (mag > 64) mag = 64;
    r.place_address = rnd64();
    case (r.mode) inside
      R_PC32, R_PLT32, R_PC16, R_PC8, R_PC64, R_GOTPCREL, R_GOTPCRELX,
      R_REX_GOTPCRELX: r.symbol_value = r.place_address + rnd_signed(mag);
      default: r.symbol_value = rnd_unsigned(mag);
    endcase
    r.symbol_size     = $urandom_range(0, 1) ? rnd_unsigned(mag) : rnd64();
    r.symbol_ok       = ($urandom_range(0, 19) != 0);
    r.explicit_addend = 1'($urandom_range(0, 1));
    r.addend          = $urandom_range(0, 1) ? rnd_signed(8) : rnd_signed(mag);
    r.field_bytes     = $urandom_range(0, 1) ? rnd_signed(8) : rnd64();
    // Section geometry: mostly small sections, some offsets past the end, some huge.
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.section_size = $urandom_range(0, 64);
      r.field_offset = $urandom_range(0, r.section_size);
    end else if (pick < 88) begin
      r.section_size = $urandom_range(0, 64);
      r.field_offset = r.section_size + $urandom_range(1, 8);
    end else if (pick < 95) begin
      r.section_size = $urandom();
      r.field_offset = $urandom_range(0, r.section_size);
    end else begin
      r.section_size = $urandom();
      r.field_offset = $urandom();
    end
    r.prefix_bytes = 16'($urandom());
    case ($urandom_range(0, 3))
      0: r.prefix_bytes[15:8] = OP_MOV_LOAD;
      1: r.prefix_bytes = {OP_GRP5, MODRM_CALL};
      2: r.prefix_bytes = {OP_GRP5, MODRM_JMP};
      default: r.prefix_bytes = r.prefix_bytes;
    endcase
    return r;
  endfunction

  // Present one item at the falling edge and hold it until it is accepted.
  task automatic send_record(input in_t r, input bit typed, input out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    expected_patches.push_back(typed ? want : predict_patch(r));
    records_sent++;
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // The receiver stalls at random, at a rate set per phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check each accepted result against the oldest expectation, and watch for a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (expected_patches.size() == 0) begin
          $display("%0t: unexpected result item, actual %0h", $time, out_data);
          errors++;
        end else begin
          oldest_patch = expected_patches.pop_front();
          compare_field("status", 64'(oldest_patch.status), 64'(out_data.status));
          compare_field("patch_value", oldest_patch.patch_value, out_data.patch_value);
          compare_field("patch_bytes", 64'(oldest_patch.patch_bytes),
                        64'(out_data.patch_bytes));
          compare_field("prefix_write", 64'(oldest_patch.prefix_write),
                        64'(out_data.prefix_write));
          compare_field("new_prefix", 64'(oldest_patch.new_prefix),
                        64'(out_data.new_prefix));
          results_checked++;
          if (oldest_patch.status == ST_OK) patched_ok++;
          if (oldest_patch.prefix_write) relaxed++;
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_patches.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    in_t r;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    idle_cycles     = 0;
    errors          = 0;
    records_sent    = 0;
    results_checked = 0;
    patched_ok      = 0;
    relaxed         = 0;

    // Directed table: checks in their fixed order, range edges, every type.
    r = base_record(R_NONE, '1, '1, '1);
    r.field_offset = 32'd100;
    r.section_size = 32'd0;
    add_row(r, 1'b1, bare_status(ST_OK));
    r = base_record(R_64, 64'd0, 64'd0, 64'd0);
    r.field_offset = 32'd65;
    add_row(r, 1'b1, bare_status(ST_OFFSET));
    add_row(base_record(R_GOT32, 64'd0, 64'd0, 64'd0), 1'b1, bare_status(ST_UNSUPPORTED));
    add_row(base_record(R_TYPE_TOP, 64'd0, 64'd0, 64'd0), 1'b1,
            bare_status(ST_UNSUPPORTED));
    r = base_record(R_64, 64'd0, 64'd0, 64'd0);
    r.field_offset = 32'd60;
    add_row(r, 1'b1, bare_status(ST_FIELD));
    r = base_record(R_SIZE64, 64'd0, 64'd0, 64'd0);
    r.symbol_ok = 1'b0;
    add_row(r, 1'b1, bare_status(ST_UNRESOLVED));
    add_row(base_record(R_64, '1, 64'd1, 64'd0), 1'b1, plain_write(64'd0, 4'd8));
    r = base_record(R_64, 64'd0, 64'd0, 64'd0);
    r.explicit_addend = 1'b0;
    r.field_bytes     = 64'h8000_0000_0000_0001;
    add_row(r, 1'b1, plain_write(64'h8000_0000_0000_0001, 4'd8));
    add_row(base_record(R_PC64, 64'd0, 64'd0, 64'd1), 1'b1, plain_write('1, 4'd8));
    r = base_record(R_SIZE64, 64'd0, 64'd0, 64'd0);
    r.symbol_size     = '1;
    r.explicit_addend = 1'b0;
    r.field_bytes     = 64'h7f;
    add_row(r, 1'b0, '0);
    add_row(base_record(R_32, 64'd0, '1, 64'd0), 1'b1, bare_status(ST_UNDERFLOW));
    add_row(base_record(R_32, 64'hFFFF_FFFF, 64'd1, 64'd0), 1'b1,
            bare_status(ST_OVERFLOW));
    add_row(base_record(R_32, 64'hFFFF_FFFF, 64'd0, 64'd0), 1'b1,
            plain_write(64'hFFFF_FFFF, 4'd4));
    add_row(base_record(R_32S, 64'd0, 64'hFFFF_FFFF_8000_0000, 64'd0), 1'b0, '0);
    add_row(base_record(R_32S, 64'd0, 64'h8000_0000, 64'd0), 1'b1,
            bare_status(ST_OVERFLOW));
    add_row(base_record(R_16, 64'hFFFF, 64'd0, 64'd0), 1'b1, plain_write(64'hFFFF, 4'd2));
    r = base_record(R_8, 64'd0, 64'd0, 64'd0);
    r.explicit_addend = 1'b0;
    r.field_bytes     = 64'h12FF;
    add_row(r, 1'b1, bare_status(ST_OVERFLOW));
    add_row(base_record(R_PC16, 64'h1000, 64'd0, 64'h9000), 1'b0, '0);
    add_row(base_record(R_PC8, 64'd127, 64'd1, 64'd0), 1'b1, bare_status(ST_OVERFLOW));
    r = base_record(R_SIZE32, 64'd0, 64'd0, 64'd0);
    r.symbol_size = 64'hFFFF_FFFF;
    add_row(r, 1'b1, plain_write(64'hFFFF_FFFF, 4'd4));
    r = base_record(R_PC32, 64'h40_1000, 64'd0, 64'h40_0ff0);
    r.explicit_addend = 1'b0;
    r.field_bytes     = 64'hDEAD_BEEF_FFFF_FFFC;
    add_row(r, 1'b0, '0);
    add_row(base_record(R_PLT32, 64'd0, 64'd0, 64'h8000_0000), 1'b0, '0);
    r = base_record(R_GOTPCREL, 64'd0, 64'd0, 64'd0);
    r.field_offset = 32'd1;
    add_row(r, 1'b1, bare_status(ST_NOPREFIX));
    add_row(base_record(R_GOTPCRELX, 64'h2000, 64'hFFFF_FFFF_FFFF_FFFC, 64'h1000),
            1'b0, '0);
    r = base_record(R_REX_GOTPCRELX, 64'h3000, 64'd0, 64'h1000);
    r.prefix_bytes = {OP_GRP5, MODRM_CALL};
    add_row(r, 1'b0, '0);
    r = base_record(R_GOTPCREL, 64'h1000, 64'd0, 64'h3000);
    r.prefix_bytes = {OP_GRP5, MODRM_JMP};
    add_row(r, 1'b0, '0);
    r = base_record(R_GOTPCRELX, 64'd0, 64'd0, 64'd0);
    r.prefix_bytes = {OP_GRP5, 8'h10};
    add_row(r, 1'b1, bare_status(ST_OPCODE));
    r = base_record(R_GOTPCREL, 64'h1_0000_0000, 64'd0, 64'd0);
    r.prefix_bytes = {OP_GRP5, MODRM_JMP};
    add_row(r, 1'b1, bare_status(ST_OVERFLOW));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random records in four traffic phases: free flow, slow sender, slow receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      repeat (RECORDS_PER_PHASE) send_record(random_record(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_patches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d relocation records sent (%0d from the directed table),",
             records_sent, directed_rows.size());
    $display("  %0d results checked: %0d patched, %0d relaxed, %0d rejected.",
             results_checked, patched_ok, relaxed, results_checked - patched_ok);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
